/* src/tccw_pkg.sv */
package tccw_pkg;

	localparam int COLUMNS_DEF   = 80;
	localparam int ROWS_DEF      = 25;
	localparam int TAB_WIDTH_DEF = 4;

	localparam int INDEX_W     = 11;
	localparam int VALUE_W     = 16;
	localparam int CHAR_W      = 8;
	localparam int NUM_W       = 32;
	localparam int BASE_W      = 5;
	localparam int ROW_IN_W    = 5;
	localparam int COL_IN_W    = 7;
	localparam int DIGIT_W     = 4;
	localparam int DIGIT_SLOTS = 32;
	localparam int SLOT_AW     = $clog2(DIGIT_SLOTS);
	localparam int SLOT_CW     = SLOT_AW + 1;
	localparam int DIV_BITS    = 8;
	localparam int DIV_STEPS   = NUM_W / DIV_BITS;
	localparam int DIV_CW      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int PC_W        = 4;

	typedef logic [1:0] op_t;
	localparam op_t OP_PUT_CHAR = 2'd0;
	localparam op_t OP_PUT_NUM  = 2'd1;
	localparam op_t OP_BACK     = 2'd2;
	localparam op_t OP_MOVE     = 2'd3;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] ATTR_BLANK = 8'h00;

	localparam logic [BASE_W-1:0] BASE_MIN     = 5'd2;
	localparam logic [BASE_W-1:0] BASE_DEFAULT = 5'd10;
	localparam logic [BASE_W-1:0] BASE_MAX     = 5'd16;

	typedef logic [PC_W-1:0] pc_t;

	typedef enum logic [3:0] {
		ACT_IDLE,
		ACT_EMIT_CHAR,
		ACT_EMIT_TAB,
		ACT_NEWLINE,
		ACT_BACK,
		ACT_EMIT_BLANK,
		ACT_MOVE,
		ACT_DIV,
		ACT_STORE,
		ACT_READ,
		ACT_EMIT_DIGIT
	} act_t;

	typedef enum logic [2:0] {
		COND_GOTO,
		COND_DISPATCH,
		COND_TAB,
		COND_CHUNK,
		COND_DIGITS,
		COND_EMIT
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		pc_t   tgt_more;
		pc_t   tgt_done;
	} ctrl_t;

	typedef struct packed {
		logic stall;
		logic tab_more;
		logic chunk_more;
		logic digit_more;
		logic emit_more;
	} stat_t;

	typedef struct packed {
		logic load;
		logic step;
		logic clr;
	} div_ctl_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] rem;
		logic               quot_zero;
		logic               chunk_more;
	} div_st_t;

	function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
		if (d < 4'd10) begin
			return 8'h30 + CHAR_W'(d);
		end else begin
			return 8'h37 + CHAR_W'(d);
		end
	endfunction

endpackage

/* src/tccw_seq.sv */
module tccw_seq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  tccw_pkg::op_t                   op,
	input  logic [tccw_pkg::CHAR_W-1:0]     character,
	output logic                            in_ready,
	output tccw_pkg::ctrl_t                 ctrl,
	input  tccw_pkg::stat_t                 st
);

	localparam tccw_pkg::pc_t PC_IDLE  = 4'd0;
	localparam tccw_pkg::pc_t PC_CHAR  = 4'd1;
	localparam tccw_pkg::pc_t PC_TAB   = 4'd2;
	localparam tccw_pkg::pc_t PC_NL    = 4'd3;
	localparam tccw_pkg::pc_t PC_BACK  = 4'd4;
	localparam tccw_pkg::pc_t PC_BLANK = 4'd5;
	localparam tccw_pkg::pc_t PC_MOVE  = 4'd6;
	localparam tccw_pkg::pc_t PC_DIV   = 4'd7;
	localparam tccw_pkg::pc_t PC_STORE = 4'd8;
	localparam tccw_pkg::pc_t PC_READ  = 4'd9;
	localparam tccw_pkg::pc_t PC_DIGIT = 4'd10;

	// control store: action, condition, target if more, target when done
	function automatic tccw_pkg::ctrl_t rom(input tccw_pkg::pc_t pc);
		tccw_pkg::ctrl_t w;
		w = '{tccw_pkg::ACT_IDLE, tccw_pkg::COND_DISPATCH, PC_IDLE, PC_IDLE};
		unique case (pc)
			PC_CHAR:  w = '{tccw_pkg::ACT_EMIT_CHAR,  tccw_pkg::COND_GOTO,   PC_IDLE,  PC_IDLE};
			PC_TAB:   w = '{tccw_pkg::ACT_EMIT_TAB,   tccw_pkg::COND_TAB,    PC_TAB,   PC_IDLE};
			PC_NL:    w = '{tccw_pkg::ACT_NEWLINE,    tccw_pkg::COND_GOTO,   PC_IDLE,  PC_IDLE};
			PC_BACK:  w = '{tccw_pkg::ACT_BACK,       tccw_pkg::COND_GOTO,   PC_BLANK, PC_BLANK};
			PC_BLANK: w = '{tccw_pkg::ACT_EMIT_BLANK, tccw_pkg::COND_GOTO,   PC_IDLE,  PC_IDLE};
			PC_MOVE:  w = '{tccw_pkg::ACT_MOVE,       tccw_pkg::COND_GOTO,   PC_IDLE,  PC_IDLE};
			PC_DIV:   w = '{tccw_pkg::ACT_DIV,        tccw_pkg::COND_CHUNK,  PC_DIV,   PC_STORE};
			PC_STORE: w = '{tccw_pkg::ACT_STORE,      tccw_pkg::COND_DIGITS, PC_DIV,   PC_READ};
			PC_READ:  w = '{tccw_pkg::ACT_READ,       tccw_pkg::COND_GOTO,   PC_DIGIT, PC_DIGIT};
			PC_DIGIT: w = '{tccw_pkg::ACT_EMIT_DIGIT, tccw_pkg::COND_EMIT,   PC_READ,  PC_IDLE};
			default:  w = '{tccw_pkg::ACT_IDLE,       tccw_pkg::COND_DISPATCH, PC_IDLE, PC_IDLE};
		endcase
		return w;
	endfunction

	function automatic tccw_pkg::pc_t dispatch(input tccw_pkg::op_t o,
		input logic [tccw_pkg::CHAR_W-1:0] ch);
		tccw_pkg::pc_t p;
		p = PC_IDLE;
		unique case (o)
			tccw_pkg::OP_PUT_CHAR: begin
				if (ch == tccw_pkg::CH_NL) begin
					p = PC_NL;
				end else if (ch == tccw_pkg::CH_TAB) begin
					p = PC_TAB;
				end else if (ch == tccw_pkg::CH_NUL) begin
					p = PC_IDLE;
				end else begin
					p = PC_CHAR;
				end
			end
			tccw_pkg::OP_PUT_NUM: p = PC_DIV;
			tccw_pkg::OP_BACK:    p = PC_BACK;
			tccw_pkg::OP_MOVE:    p = PC_MOVE;
		endcase
		return p;
	endfunction

	tccw_pkg::pc_t pc_q;
	tccw_pkg::pc_t pc_d;
	logic          more;

	assign ctrl     = rom(pc_q);
	assign in_ready = (ctrl.cond == tccw_pkg::COND_DISPATCH);

	always_comb begin
		unique case (ctrl.cond)
			tccw_pkg::COND_TAB:    more = st.tab_more;
			tccw_pkg::COND_CHUNK:  more = st.chunk_more;
			tccw_pkg::COND_DIGITS: more = st.digit_more;
			tccw_pkg::COND_EMIT:   more = st.emit_more;
			default:               more = 1'b0;
		endcase
		if (ctrl.cond == tccw_pkg::COND_DISPATCH) begin
			pc_d = in_valid ? dispatch(op, character) : PC_IDLE;
		end else if (st.stall) begin
			pc_d = pc_q;
		end else begin
			pc_d = more ? ctrl.tgt_more : ctrl.tgt_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		st.stall |=> pc_q == $past(pc_q))
		else $error("step advanced during output stall");

	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= PC_DIGIT)
		else $error("step counter out of program");

	a_num_entry: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == tccw_pkg::OP_PUT_NUM |=> pc_q == PC_DIV)
		else $error("put number did not enter conversion");

endmodule

/* src/tccw_div.sv */
module tccw_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tccw_pkg::div_ctl_t            ctl,
	input  logic [tccw_pkg::NUM_W-1:0]    value,
	input  logic [tccw_pkg::BASE_W-1:0]   base,
	output tccw_pkg::div_st_t             st
);

	logic [tccw_pkg::NUM_W-1:0]    val_q;
	logic [tccw_pkg::DIGIT_W-1:0]  rem_q;
	logic [tccw_pkg::BASE_W-1:0]   base_q;
	logic [tccw_pkg::DIV_CW-1:0]   cnt_q;
	logic [tccw_pkg::BASE_W-1:0]   base_n;
	logic [tccw_pkg::BASE_W-1:0]   r;
	logic [tccw_pkg::DIV_BITS-1:0] qbits;
	logic [tccw_pkg::DIGIT_W-1:0]  rem_d;
	logic                          cnt_last;

	always_comb begin
		if (base < tccw_pkg::BASE_MIN) begin
			base_n = tccw_pkg::BASE_DEFAULT;
		end else if (base > tccw_pkg::BASE_MAX) begin
			base_n = tccw_pkg::BASE_MAX;
		end else begin
			base_n = base;
		end
	end

	// restoring division, one byte of dividend per step
	always_comb begin
		r = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < tccw_pkg::DIV_BITS; i++) begin
			r = {r[tccw_pkg::BASE_W-2:0], val_q[tccw_pkg::NUM_W-1-i]};
			qbits[tccw_pkg::DIV_BITS-1-i] = (r >= base_q);
			if (r >= base_q) begin
				r = r - base_q;
			end
		end
		rem_d = r[tccw_pkg::DIGIT_W-1:0];
	end

	assign cnt_last = (cnt_q == tccw_pkg::DIV_CW'(tccw_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_q  <= value;
			base_q <= base_n;
			rem_q  <= '0;
		end else if (ctl.step) begin
			val_q <= {val_q[tccw_pkg::NUM_W-tccw_pkg::DIV_BITS-1:0], qbits};
			rem_q <= rem_d;
		end else if (ctl.clr) begin
			rem_q <= '0;
		end
	end

	assign st.rem        = rem_q;
	assign st.quot_zero  = (val_q == '0);
	assign st.chunk_more = !cnt_last;

	a_clr_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clr |-> cnt_q == '0)
		else $error("digit taken mid division");

	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && !ctl.load |=> rem_q < base_q)
		else $error("remainder not below base");

	a_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> cnt_q == '0 && rem_q == '0)
		else $error("division did not restart");

endmodule

/* src/tccw_dp.sv */
module tccw_dp #(
	parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tccw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  tccw_pkg::ctrl_t                 ctrl,
	output tccw_pkg::stat_t                 st,
	input  logic [tccw_pkg::CHAR_W-1:0]     character,
	input  logic [tccw_pkg::CHAR_W-1:0]     attribute,
	input  logic [tccw_pkg::NUM_W-1:0]      number_value,
	input  logic [tccw_pkg::BASE_W-1:0]     number_base,
	input  logic [tccw_pkg::ROW_IN_W-1:0]   row,
	input  logic [tccw_pkg::COL_IN_W-1:0]   column,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tccw_pkg::INDEX_W-1:0]    cell_index,
	output logic [tccw_pkg::VALUE_W-1:0]    cell_value,
	output logic                            out_last
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int CUR_W  = $clog2(CELLS);
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int TAB_CW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;

	logic [CUR_W-1:0]              cursor_q, cursor_d;
	logic [COL_W-1:0]              col_q, col_d;
	logic [TAB_CW-1:0]             tab_q;
	logic [tccw_pkg::SLOT_CW-1:0]  n_q;
	logic [tccw_pkg::CHAR_W-1:0]   char_q, attr_q;
	logic [tccw_pkg::ROW_IN_W-1:0] row_in_q;
	logic [tccw_pkg::COL_IN_W-1:0] col_in_q;
	logic [tccw_pkg::DIGIT_W-1:0]  mem [tccw_pkg::DIGIT_SLOTS];
	logic [tccw_pkg::DIGIT_W-1:0]  rd_q;
	logic [tccw_pkg::SLOT_AW-1:0]  rd_addr;

	logic                          out_valid_q, out_last_q;
	logic [tccw_pkg::INDEX_W-1:0]  idx_q;
	logic [tccw_pkg::VALUE_W-1:0]  val_q;

	logic                          emit, busy, fire, advance, emit_last;
	logic [tccw_pkg::CHAR_W-1:0]   emit_ch, emit_attr;
	logic                          tab_last;

	logic [CUR_W-1:0]              cur_inc, cur_dec, cur_nl, cur_mv;
	logic [COL_W-1:0]              col_inc, col_dec, col_c;
	logic [ROW_W-1:0]              row_c;
	logic [CUR_W:0]                nl_sum;

	tccw_pkg::div_ctl_t            div_ctl;
	tccw_pkg::div_st_t             div_st;

	assign div_ctl.load = accept;
	assign div_ctl.step = (ctrl.act == tccw_pkg::ACT_DIV);
	assign div_ctl.clr  = (ctrl.act == tccw_pkg::ACT_STORE);

	tccw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.value  (number_value),
		.base   (number_base),
		.st     (div_st)
	);

	assign tab_last = (tab_q == TAB_CW'(TAB_WIDTH - 1));

	always_comb begin
		emit      = 1'b1;
		advance   = 1'b1;
		emit_ch   = char_q;
		emit_attr = attr_q;
		emit_last = 1'b1;
		unique case (ctrl.act)
			tccw_pkg::ACT_EMIT_CHAR: ;
			tccw_pkg::ACT_EMIT_TAB: begin
				emit_ch   = tccw_pkg::CH_SPACE;
				emit_last = tab_last;
			end
			tccw_pkg::ACT_EMIT_BLANK: begin
				emit_ch   = tccw_pkg::CH_SPACE;
				emit_attr = tccw_pkg::ATTR_BLANK;
				advance   = 1'b0;
			end
			tccw_pkg::ACT_EMIT_DIGIT: begin
				emit_ch   = tccw_pkg::digit_glyph(rd_q);
				emit_last = (n_q == '0);
			end
			default: begin
				emit    = 1'b0;
				advance = 1'b0;
			end
		endcase
	end

	assign busy = out_valid_q && !out_ready;
	assign fire = emit && !busy;

	// cursor arithmetic
	always_comb begin
		cur_inc = (cursor_q == CUR_W'(CELLS - 1)) ? '0 : cursor_q + 1'b1;
		col_inc = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
		cur_dec = (cursor_q == '0) ? CUR_W'(CELLS - 1) : cursor_q - 1'b1;
		col_dec = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - 1'b1;
		nl_sum  = {1'b0, cursor_q} + (CUR_W + 1)'(COLUMNS) - (CUR_W + 1)'(col_q);
		cur_nl  = (nl_sum >= (CUR_W + 1)'(CELLS)) ? '0 : nl_sum[CUR_W-1:0];
		row_c   = (8'(row_in_q) >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(row_in_q);
		col_c   = (9'(col_in_q) >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1) : COL_W'(col_in_q);
		cur_mv  = CUR_W'(row_c) * CUR_W'(COLUMNS) + CUR_W'(col_c);

		cursor_d = cursor_q;
		col_d    = col_q;
		unique case (ctrl.act)
			tccw_pkg::ACT_NEWLINE: begin
				cursor_d = cur_nl;
				col_d    = '0;
			end
			tccw_pkg::ACT_BACK: begin
				cursor_d = cur_dec;
				col_d    = col_dec;
			end
			tccw_pkg::ACT_MOVE: begin
				cursor_d = cur_mv;
				col_d    = col_c;
			end
			default: begin
				if (fire && advance) begin
					cursor_d = cur_inc;
					col_d    = col_inc;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			col_q       <= '0;
			tab_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cursor_q <= cursor_d;
			col_q    <= col_d;
			if (accept) begin
				tab_q <= '0;
			end else if (fire && ctrl.act == tccw_pkg::ACT_EMIT_TAB) begin
				tab_q <= tab_q + 1'b1;
			end
			if (accept) begin
				n_q <= '0;
			end else if (ctrl.act == tccw_pkg::ACT_STORE) begin
				n_q <= n_q + 1'b1;
			end else if (ctrl.act == tccw_pkg::ACT_READ) begin
				n_q <= n_q - 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_q   <= character;
			attr_q   <= attribute;
			row_in_q <= row;
			col_in_q <= column;
		end
		if (fire) begin
			idx_q      <= tccw_pkg::INDEX_W'(cursor_q);
			val_q      <= {emit_attr, emit_ch};
			out_last_q <= emit_last;
		end
	end

	// digit store
	assign rd_addr = n_q[tccw_pkg::SLOT_AW-1:0] - 1'b1;

	always_ff @(posedge clk) begin
		if (ctrl.act == tccw_pkg::ACT_STORE) begin
			mem[n_q[tccw_pkg::SLOT_AW-1:0]] <= div_st.rem;
		end
		if (ctrl.act == tccw_pkg::ACT_READ) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign st.stall      = emit && busy;
	assign st.tab_more   = !tab_last;
	assign st.chunk_more = div_st.chunk_more;
	assign st.digit_more = !div_st.quot_zero
		&& (n_q != tccw_pkg::SLOT_CW'(tccw_pkg::DIGIT_SLOTS - 1));
	assign st.emit_more  = (n_q != '0);

	assign out_valid  = out_valid_q;
	assign cell_index = idx_q;
	assign cell_value = val_q;
	assign out_last   = out_last_q;

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_W'(CELLS - 1))
		else $error("cursor beyond screen");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(COLUMNS - 1))
		else $error("column tracker beyond row");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= tccw_pkg::SLOT_CW'(tccw_pkg::DIGIT_SLOTS))
		else $error("digit count overflow");

endmodule

/* src/text_console_cell_writer_core.sv */
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tuser op, s_tdata command fields
// m_*      out  m_tvalid/m_tready  m_tdata cell index and value, m_tlast last write
//
// Command steps: backspace moves the cursor back, then writes a blank; tab writes TAB_WIDTH
// spaces; put number runs, per digit, four byte steps of the divider and one store,
// then one read and one emit.
// Reset sets the cursor to the top left cell; the digit store is not cleared.
// An emit step waits while the output register holds an untaken transaction.
module text_console_cell_writer_core #(
	parameter int COLUMNS   = tccw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tccw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tccw_pkg::TAB_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// character[7:0], attribute[15:8], number_value[47:16], number_base[52:48],
	// row[57:53], column[64:58], zero fill
	input  logic [71:0] s_tdata,
	// op[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// cell_index[10:0], cell_value[26:11], zero fill
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	logic                            accept;
	tccw_pkg::ctrl_t                 ctrl;
	tccw_pkg::stat_t                 st;
	logic [tccw_pkg::INDEX_W-1:0]    cell_index;
	logic [tccw_pkg::VALUE_W-1:0]    cell_value;

	assign accept = s_tvalid && s_tready;

	tccw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.op        (s_tuser),
		.character (s_tdata[7:0]),
		.in_ready  (s_tready),
		.ctrl      (ctrl),
		.st        (st)
	);

	tccw_dp #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.ctrl         (ctrl),
		.st           (st),
		.character    (s_tdata[7:0]),
		.attribute    (s_tdata[15:8]),
		.number_value (s_tdata[47:16]),
		.number_base  (s_tdata[52:48]),
		.row          (s_tdata[57:53]),
		.column       (s_tdata[64:58]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.cell_index   (cell_index),
		.cell_value   (cell_value),
		.out_last     (m_tlast)
	);

	assign m_tdata = {5'b0, cell_value, cell_index};

endmodule
